>>> sv/ppxrgba_pkg.sv
package ppxrgba_pkg;

   localparam int PALETTES        = 20;
   localparam int CODE_W          = 8;
   localparam int PALETTE_ENTRIES = 1 << CODE_W;
   localparam int MEM_DEPTH       = PALETTES * PALETTE_ENTRIES;
   localparam int ADDR_W          = $clog2(MEM_DEPTH);
   localparam int PAL_IDX_W       = (PALETTES > 1) ? $clog2(PALETTES) : 1;

   localparam int OP_W      = 2;
   localparam int PAL_SEL_W = 5;
   localparam int PAL_CMP_W = PAL_SEL_W + 1;
   localparam int WORD_W    = 16;
   localparam int CHAN_W    = 8;

   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = '0;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = '1;

   // x*255/31 for x < 32 is computed as (x * 255 * 8457) >> 18, exact over the range.
   localparam int                   EXP5_PROD_W = 26;
   localparam int                   EXP5_SHIFT  = 18;
   localparam logic [EXP5_PROD_W-1:0] EXP5_MUL  = 26'd2156535;

   // x*255/63 for x < 64 is computed as (x * 255 * 16645) >> 20, exact over the range.
   localparam int                   EXP6_PROD_W = 29;
   localparam int                   EXP6_SHIFT  = 20;
   localparam logic [EXP6_PROD_W-1:0] EXP6_MUL  = 29'd4244475;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_INDEXED = 2'd1,
      OP_DIRECT  = 2'd2
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [PAL_SEL_W-1:0] palette_select;
      logic [CODE_W-1:0]    pixel_code;
      logic [WORD_W-1:0]    color_word;
   } req_item_type;

   typedef struct packed {
      logic              valid;
      logic              direct;
      logic              transparent;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] entry;
      logic [WORD_W-1:0] entry0;
   } stage_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_type;

   function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] x);
      logic [EXP5_PROD_W-1:0] prod;
      prod = EXP5_PROD_W'(x) * EXP5_MUL;
      return prod[EXP5_SHIFT +: CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] x);
      logic [EXP6_PROD_W-1:0] prod;
      prod = EXP6_PROD_W'(x) * EXP6_MUL;
      return prod[EXP6_SHIFT +: CHAN_W];
   endfunction

endpackage

>>> sv/ppxrgba_req_if.sv
interface ppxrgba_req_if import ppxrgba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [PAL_SEL_W-1:0] palette_select;
   logic [CODE_W-1:0]    pixel_code;
   logic [WORD_W-1:0]    color_word;

   modport source (output valid, output op, output palette_select, output pixel_code,
                   output color_word, input ready);
   modport sink (input valid, input op, input palette_select, input pixel_code,
                 input color_word, output ready);
endinterface

>>> sv/ppxrgba_rsp_if.sv
interface ppxrgba_rsp_if import ppxrgba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

>>> sv/ppxrgba_lookup.sv
module ppxrgba_lookup import ppxrgba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_item_type        item,
   input  logic [PALETTES-1:0] colorkey_mask,
   input  logic                stage_take,
   output logic                ready,
   output stage_type           stage
);

   logic [WORD_W-1:0] palette_mem [MEM_DEPTH];

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_direct_ff;
   logic              s1_transp_ff;
   logic [WORD_W-1:0] s1_word_ff;
   logic [WORD_W-1:0] rd_entry_ff;
   logic [WORD_W-1:0] rd_entry0_ff;

   logic              pal_ok;
   logic              keyed;
   logic              wr_en;
   logic              has_result;
   logic              direct;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] base_addr;

   assign pal_ok    = PAL_CMP_W'(item.palette_select) < PAL_CMP_W'(PALETTES);
   assign keyed     = colorkey_mask[item.palette_select[PAL_IDX_W-1:0]];
   assign rd_addr   = ADDR_W'({item.palette_select, item.pixel_code});
   assign base_addr = ADDR_W'({item.palette_select, CODE_W'(0)});

   always_comb begin
      wr_en      = 1'b0;
      has_result = 1'b0;
      direct     = 1'b0;
      case (op_type'(item.op))
         OP_WRITE: begin
            wr_en = accept && pal_ok;
         end
         OP_INDEXED: begin
            has_result = pal_ok;
         end
         OP_DIRECT: begin
            has_result = 1'b1;
            direct     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Both the addressed entry and entry 0 are read together, so the fallback needs no second read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[rd_addr] <= item.color_word;
      end
      if (accept) begin
         rd_entry_ff  <= palette_mem[rd_addr];
         rd_entry0_ff <= palette_mem[base_addr];
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = has_result;
      end else if (stage_take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_direct_ff <= direct;
         s1_transp_ff <= keyed && (item.pixel_code == '0);
         s1_word_ff   <= item.color_word;
      end
   end

   assign ready = !s1_valid_ff || stage_take;

   assign stage.valid       = s1_valid_ff;
   assign stage.direct      = s1_direct_ff;
   assign stage.transparent = s1_transp_ff;
   assign stage.word        = s1_word_ff;
   assign stage.entry       = rd_entry_ff;
   assign stage.entry0      = rd_entry0_ff;

endmodule

>>> sv/ppxrgba_format.sv
module ppxrgba_format import ppxrgba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   input  logic      rsp_ready,
   output logic      stage_take,
   output logic      rsp_valid,
   output pixel_type rsp_pixel
);

   logic              out_valid_ff;
   logic              out_valid_in;
   pixel_type         out_pixel_ff;
   pixel_type         out_pixel_in;
   logic              load;
   logic [WORD_W-1:0] color;

   assign load = !out_valid_ff || rsp_ready;

   // An indexed entry of zero falls back to entry 0 of the same palette.
   assign color = (stage.entry != '0) ? stage.entry : stage.entry0;

   always_comb begin
      if (stage.direct) begin
         out_pixel_in.red   = expand5(stage.word[15:11]);
         out_pixel_in.green = expand6(stage.word[10:5]);
         out_pixel_in.blue  = expand5(stage.word[4:0]);
         out_pixel_in.alpha = (stage.word == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      end else begin
         out_pixel_in.red   = expand5(color[4:0]);
         out_pixel_in.green = expand5(color[9:5]);
         out_pixel_in.blue  = expand5(color[14:10]);
         out_pixel_in.alpha = stage.transparent ? ALPHA_CLEAR : ALPHA_OPAQUE;
      end
   end

   assign out_valid_in = load ? stage.valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign stage_take = load;
   assign rsp_valid  = out_valid_ff;
   assign rsp_pixel  = out_pixel_ff;

endmodule

>>> sv/palette_pixel_to_rgba8888.sv
// An accepted pixel item passes through the lookup stage register and then the output
// register before its result is offered on the response channel.
// Throughput: one item per cycle; the palette memory reads the addressed entry and
// entry 0 of the palette in the same cycle, and a result-side stall reaches the input
// ready combinationally once both the stage and the output register are full.
// Reset clears the pipeline valid bits and the colorkey mask; the palette memory
// is not cleared and an entry holds no defined value until it is written.
module palette_pixel_to_rgba8888 import ppxrgba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   ppxrgba_req_if.sink         req_chan,
   ppxrgba_rsp_if.source       rsp_chan,
   input  logic                csr_wr_en,
   input  logic [PALETTES-1:0] csr_wr_data
);

   logic [PALETTES-1:0] colorkey_mask_ff;
   logic [PALETTES-1:0] colorkey_mask_in;
   logic                accept;
   logic                lookup_ready;
   logic                stage_take;
   req_item_type        item;
   stage_type           stage;
   pixel_type           rsp_pixel;
   logic                rsp_valid;

   assign colorkey_mask_in = csr_wr_en ? csr_wr_data : colorkey_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         colorkey_mask_ff <= '0;
      end else begin
         colorkey_mask_ff <= colorkey_mask_in;
      end
   end

   assign item.op             = req_chan.op;
   assign item.palette_select = req_chan.palette_select;
   assign item.pixel_code     = req_chan.pixel_code;
   assign item.color_word     = req_chan.color_word;

   assign accept         = req_chan.valid && lookup_ready;
   assign req_chan.ready = lookup_ready;

   ppxrgba_lookup u_lookup (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item          (item),
      .colorkey_mask (colorkey_mask_ff),
      .stage_take    (stage_take),
      .ready         (lookup_ready),
      .stage         (stage)
   );

   ppxrgba_format u_format (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .rsp_ready  (rsp_chan.ready),
      .stage_take (stage_take),
      .rsp_valid  (rsp_valid),
      .rsp_pixel  (rsp_pixel)
   );

   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.red   = rsp_pixel.red;
   assign rsp_chan.green = rsp_pixel.green;
   assign rsp_chan.blue  = rsp_pixel.blue;
   assign rsp_chan.alpha = rsp_pixel.alpha;

   // The input side only stalls when both the stage and the output register are full.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled while the output side can move");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.alpha == ALPHA_CLEAR || rsp_chan.alpha == ALPHA_OPAQUE))
      else $error("alpha is neither transparent nor opaque");

   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule
